// ----- rtl/pac_pkg.sv -----
// Shared types and constants for the proximity alarm controller.
// No dependencies; imported by every module in rtl/.
package pac_pkg;

	localparam int DIST_W   = 16;
	localparam int COLOUR_W = 24;
	localparam int BLINK_W  = 16;
	localparam int TIME_W   = 24;
	localparam int IDX_W    = 3;
	localparam int IN_W     = 24;  // 19 payload bits, padded to bytes
	localparam int OUT_W    = 32;  // 27 payload bits, padded to bytes

	typedef enum logic [1:0] {
		MODE_OFF   = 2'd0,
		MODE_WATCH = 2'd1,
		MODE_ALARM = 2'd2,
		MODE_TEST  = 2'd3
	} mode_t;

	localparam logic [IDX_W-1:0] CFG_COLOUR_A  = 3'd0;
	localparam logic [IDX_W-1:0] CFG_COLOUR_B  = 3'd1;
	localparam logic [IDX_W-1:0] CFG_BLINK     = 3'd2;
	localparam logic [IDX_W-1:0] CFG_TRIGGER   = 3'd3;
	localparam logic [IDX_W-1:0] CFG_TIMEOUT   = 3'd4;

	localparam logic [COLOUR_W-1:0] COLOUR_A_RST = 24'hFF0000;
	localparam logic [COLOUR_W-1:0] COLOUR_B_RST = 24'h0000FF;
	localparam logic [BLINK_W-1:0]  BLINK_RST    = 16'd250;
	localparam logic [DIST_W-1:0]   TRIGGER_RST  = 16'd150;
	localparam logic [TIME_W-1:0]   TIMEOUT_RST  = 24'd3000;

	typedef struct packed {
		logic [COLOUR_W-1:0] colour_a;
		logic [COLOUR_W-1:0] colour_b;
		logic [BLINK_W-1:0]  blink_period;
		logic [DIST_W-1:0]   trigger_dist;
		logic [TIME_W-1:0]   timeout;
	} cfg_t;

	typedef struct packed {
		logic [DIST_W-1:0] distance;
		logic              turn_on;
		logic              turn_off;
		logic              test;
	} tick_t;

	typedef struct packed {
		mode_t               mode;
		logic                on_pending;
		logic                off_pending;
		logic [TIME_W-1:0]   since_detect;
		logic [BLINK_W-1:0]  since_blink;
		logic [TIME_W-1:0]   since_test;
		logic                colour_phase;
		logic                buzzer;
		logic [COLOUR_W-1:0] led;
	} ctl_state_t;

endpackage

// ----- rtl/proximity_alarm_controller.sv -----
// Top level of the proximity alarm controller: input register, state update,
// result register. Depends on pac_pkg, pac_cfg and pac_step.
//
//  channel   dir  fields (low bit up)                              accepted when
//  s_axis    in   distance_mm[15:0] on[16] off[17] test[18] pad     tvalid & tready
//  m_axis    out  mode[1:0] buzzer[2] red[10:3] green[18:11]
//                 blue[26:19] pad                                   tvalid & tready
//  cfg       in   cfg_index selects register, cfg_data value        cfg_we
//
// One tick per clock sustained while the sink takes each result; an accepted
// tick waits in the input register, then its result loads the result register.
// Controller state is written in the same edge that loads the result register.
// A stalled result holds the input register; s_axis_tready drops only when both
// the input and result registers are full and the sink holds off.
// Reset clears controller state and valid flags, LED dark; cfg gets defaults.
module proximity_alarm_controller
	import pac_pkg::*;
(
	input  logic                clk,
	input  logic                arst_n,
	input  logic                s_axis_tvalid,
	output logic                s_axis_tready,
	input  logic [IN_W-1:0]     s_axis_tdata,   // distance_mm, turn_on, turn_off, test
	output logic                m_axis_tvalid,
	input  logic                m_axis_tready,
	output logic [OUT_W-1:0]    m_axis_tdata,   // mode, buzzer, red, green, blue
	input  logic                cfg_we,
	input  logic [IDX_W-1:0]    cfg_index,
	input  logic [COLOUR_W-1:0] cfg_data
);

	cfg_t       cfg;
	ctl_state_t state_q;
	ctl_state_t state_nxt;
	tick_t      tick_s1;
	logic       valid_s1;
	logic       out_valid_q;
	logic [OUT_W-1:0] out_data_q;
	logic       advance;

	pac_cfg u_cfg (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.cfg       (cfg)
	);

	pac_step u_step (
		.cfg  (cfg),
		.tick (tick_s1),
		.cur  (state_q),
		.nxt  (state_nxt)
	);

	assign advance       = valid_s1 && (!out_valid_q || m_axis_tready);
	assign s_axis_tready = !valid_s1 || advance;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (s_axis_tready) begin
			valid_s1 <= s_axis_tvalid;
		end
	end

	always_ff @(posedge clk) begin
		if (s_axis_tready && s_axis_tvalid) begin
			tick_s1.distance <= s_axis_tdata[DIST_W-1:0];
			tick_s1.turn_on  <= s_axis_tdata[DIST_W];
			tick_s1.turn_off <= s_axis_tdata[DIST_W+1];
			tick_s1.test     <= s_axis_tdata[DIST_W+2];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (advance) begin
				state_q     <= state_nxt;
				out_valid_q <= 1'b1;
			end else if (m_axis_tready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			out_data_q <= {5'b0, state_nxt.led[7:0], state_nxt.led[15:8],
				state_nxt.led[23:16], state_nxt.buzzer, state_nxt.mode};
		end
	end

	assign m_axis_tvalid = out_valid_q;
	assign m_axis_tdata  = out_data_q;

	// a test request always leaves the controller in testing mode
	a_test_enters: assert property (@(posedge clk) disable iff (!arst_n)
		advance && tick_s1.test |=> state_q.mode == MODE_TEST)
		else $error("test request did not enter testing mode");

	// watching mode never has the buzzer sounding
	a_watch_quiet: assert property (@(posedge clk) disable iff (!arst_n)
		state_q.mode == MODE_WATCH |-> !state_q.buzzer)
		else $error("buzzer on while watching");

	// input stalls only when both registers are occupied and the sink holds off
	a_stall_cause: assert property (@(posedge clk) disable iff (!arst_n)
		!s_axis_tready |-> valid_s1 && out_valid_q && !m_axis_tready)
		else $error("input stalled without cause");

	// controller state changes only on a transaction through the core
	a_state_hold: assert property (@(posedge clk) disable iff (!arst_n)
		!advance |=> $stable(state_q))
		else $error("state changed without a tick");

endmodule

// ----- rtl/pac_cfg.sv -----
// Configuration register bank for the proximity alarm controller.
// Depends on pac_pkg.
module pac_cfg
	import pac_pkg::*;
(
	input  logic                clk,
	input  logic                arst_n,
	input  logic                cfg_we,
	input  logic [IDX_W-1:0]    cfg_index,
	input  logic [COLOUR_W-1:0] cfg_data,
	output cfg_t                cfg
);

	cfg_t cfg_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.colour_a     <= COLOUR_A_RST;
			cfg_q.colour_b     <= COLOUR_B_RST;
			cfg_q.blink_period <= BLINK_RST;
			cfg_q.trigger_dist <= TRIGGER_RST;
			cfg_q.timeout      <= TIMEOUT_RST;
		end else if (cfg_we) begin
			unique case (cfg_index)
				CFG_COLOUR_A: cfg_q.colour_a     <= cfg_data;
				CFG_COLOUR_B: cfg_q.colour_b     <= cfg_data;
				CFG_BLINK:    cfg_q.blink_period <= cfg_data[BLINK_W-1:0];
				CFG_TRIGGER:  cfg_q.trigger_dist <= cfg_data[DIST_W-1:0];
				CFG_TIMEOUT:  cfg_q.timeout      <= cfg_data[TIME_W-1:0];
				default: ;
			endcase
		end
	end

	assign cfg = cfg_q;

endmodule

// ----- rtl/pac_step.sv -----
// Next-state logic for one millisecond tick of the alarm controller.
// Depends on pac_pkg; purely combinational.
module pac_step
	import pac_pkg::*;
(
	input  cfg_t       cfg,
	input  tick_t      tick,
	input  ctl_state_t cur,
	output ctl_state_t nxt
);

	always_comb begin
		ctl_state_t s;
		logic       far;
		logic       b_first;
		logic       do_blink;
		s        = cur;
		far      = tick.distance > cfg.trigger_dist;
		b_first  = 1'b0;
		do_blink = 1'b0;

		if (tick.turn_on)  s.on_pending  = 1'b1;
		if (tick.turn_off) s.off_pending = 1'b1;

		if (s.since_detect != '1) s.since_detect = s.since_detect + 1'b1;
		if (s.since_test   != '1) s.since_test   = s.since_test + 1'b1;
		if (s.since_blink  != '1) s.since_blink  = s.since_blink + 1'b1;

		// test request overrides whatever mode we were in
		if (tick.test) begin
			s.mode         = MODE_TEST;
			s.since_test   = '0;
			s.since_blink  = '0;
			s.colour_phase = 1'b0;
		end

		unique case (s.mode)
			MODE_OFF: begin
				s.buzzer = 1'b0;
				s.led    = '0;
				if (s.on_pending) begin
					s.on_pending = 1'b0;
					s.mode       = MODE_WATCH;
				end
			end
			MODE_WATCH: begin
				if (s.off_pending) begin
					s.off_pending = 1'b0;
					s.mode        = MODE_OFF;
				end else if (!far) begin
					s.mode         = MODE_ALARM;
					s.since_detect = '0;
					s.since_blink  = '0;
					s.colour_phase = 1'b0;
				end
			end
			MODE_ALARM: begin
				if (s.off_pending) begin
					s.off_pending = 1'b0;
					s.mode        = MODE_OFF;
				end else if (far && (s.since_detect > cfg.timeout)) begin
					s.mode   = MODE_WATCH;
					s.buzzer = 1'b0;
					s.led    = '0;
				end else begin
					if (!far) s.since_detect = '0;
					b_first  = 1'b1;
					do_blink = 1'b1;
				end
			end
			MODE_TEST: begin
				if (s.since_test > cfg.timeout) begin
					s.mode   = MODE_OFF;
					s.buzzer = 1'b0;
					s.led    = '0;
				end else begin
					do_blink = 1'b1;
				end
			end
		endcase

		if (do_blink) begin
			s.buzzer = 1'b1;
			if (s.since_blink >= cfg.blink_period) begin
				s.since_blink  = '0;
				s.colour_phase = !s.colour_phase;
				s.led = (s.colour_phase == b_first) ? cfg.colour_b : cfg.colour_a;
			end
		end

		nxt = s;
	end

endmodule
